// ----- hw/rtl/tstk_pkg.sv -----
// Shared types, codes and default sizes for the transactional stack.
package tstk_pkg;

   localparam int VALUE_W         = 32;
   localparam int LOG_ENTRY_W     = VALUE_W + 1;
   localparam int DEPTH_OUT_W     = 9;
   localparam int STACK_DEPTH_DEF = 256;
   localparam int LOG_DEPTH_DEF   = 512;
   localparam int NEST_DEPTH_DEF  = 16;

   typedef enum logic [2:0] {
      KIND_PUSH     = 3'd0,
      KIND_POP      = 3'd1,
      KIND_BEGIN    = 3'd2,
      KIND_COMMIT   = 3'd3,
      KIND_ROLLBACK = 3'd4,
      KIND_PEEK     = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_NO_TXN     = 3'd1,
      STATUS_STACK_FULL = 3'd2,
      STATUS_LOG_FULL   = 3'd3,
      STATUS_NEST_FULL  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UNDO_ADDR,
      ST_UNDO_DATA,
      ST_FETCH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]                kind;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] top_value;
      logic [DEPTH_OUT_W-1:0]    depth;
      logic [2:0]                status;
   } rsp_type;

endpackage

// ----- hw/rtl/transactional_stack_core.sv -----
// Transactional value stack with nested rollback: controller and memories.
// Push, begin, commit and peek go straight to done; a pop leaving values refetches the top.
// A rollback undoes each log entry above its mark, then refetches the top if values remain.
// One operation is in flight at a time; a finished result waits in the output register.
// Reset is synchronous and active high; it empties the stack, the log and all transactions.
// Memory contents are not cleared; only entries below their counts are ever read.
module transactional_stack_core
   import tstk_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int LOG_DEPTH   = LOG_DEPTH_DEF,
   parameter int NEST_DEPTH  = NEST_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Count widths hold the full depth; address widths index the memories.
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int SA_W  = $clog2(STACK_DEPTH);
   localparam int LC_W  = $clog2(LOG_DEPTH + 1);
   localparam int LA_W  = $clog2(LOG_DEPTH);
   localparam int NC_W  = $clog2(NEST_DEPTH + 1);
   localparam int NA_W  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

   localparam logic [CNT_W-1:0] STACK_MAX = CNT_W'(STACK_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
   localparam logic [LC_W-1:0]  LOG_MAX   = LC_W'(LOG_DEPTH);
   localparam logic [LC_W-1:0]  LOG_ONE   = LC_W'(1);
   localparam logic [NC_W-1:0]  NEST_MAX  = NC_W'(NEST_DEPTH);
   localparam logic [NC_W-1:0]  NEST_ONE  = NC_W'(1);

   // Control state.
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LC_W-1:0]  log_cnt_ff, log_cnt_in;
   logic [NC_W-1:0]  nest_ff, nest_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload state. The top register mirrors the stack entry below the count
   // whenever the stack is not empty, so a pop can log its value at once.
   logic [VALUE_W-1:0] top_ff, top_in;
   status_type         status_ff, status_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic                   stk_wr_en, stk_rd_en;
   logic [SA_W-1:0]        stk_wr_addr, stk_rd_addr;
   logic [VALUE_W-1:0]     stk_wr_data, stk_rd_data;
   logic                   log_wr_en, log_rd_en;
   logic [LA_W-1:0]        log_wr_addr, log_rd_addr;
   logic [LOG_ENTRY_W-1:0] log_wr_data, log_rd_data;
   logic                   mark_wr_en, mark_rd_en;
   logic [NA_W-1:0]        mark_wr_addr, mark_rd_addr;
   logic [LC_W-1:0]        mark_wr_data, mark_rd_data;

   logic             in_txn;
   logic             log_full;
   logic             req_fire;
   logic [CNT_W-1:0] cnt_dec;
   logic [CNT_W-1:0] cnt_dec2;
   logic [LC_W-1:0]  log_cnt_dec;
   logic [NC_W-1:0]  nest_dec;

   assign in_txn      = (nest_ff != '0);
   assign log_full    = (log_cnt_ff >= LOG_MAX);
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign cnt_dec     = cnt_ff - CNT_ONE;
   assign cnt_dec2    = cnt_ff - CNT_TWO;
   assign log_cnt_dec = log_cnt_ff - LOG_ONE;
   assign nest_dec    = nest_ff - NEST_ONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         log_cnt_ff   <= '0;
         nest_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         log_cnt_ff   <= log_cnt_in;
         nest_ff      <= nest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sequencer. An accepted operation updates the counts and memories in its
   // first cycle. A pop then refetches the new top, and a rollback walks the
   // log back to its start mark one entry at a time (address, then data),
   // then refetches any top left. Every operation ends in the done state, which
   // moves the result into the output register as soon as that is free.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      log_cnt_in   = log_cnt_ff;
      nest_in      = nest_ff;
      top_in       = top_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      stk_wr_en    = 1'b0;
      stk_wr_addr  = cnt_ff[SA_W-1:0];
      stk_wr_data  = req_data.value;
      stk_rd_en    = 1'b0;
      stk_rd_addr  = cnt_dec[SA_W-1:0];
      log_wr_en    = 1'b0;
      log_wr_addr  = log_cnt_ff[LA_W-1:0];
      log_wr_data  = {1'b1, VALUE_W'(0)};
      log_rd_en    = 1'b0;
      log_rd_addr  = log_cnt_dec[LA_W-1:0];
      mark_wr_en   = 1'b0;
      mark_wr_addr = nest_ff[NA_W-1:0];
      mark_wr_data = log_cnt_ff;
      mark_rd_en   = 1'b0;
      mark_rd_addr = nest_dec[NA_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               status_in = STATUS_OK;
               state_in  = ST_DONE;
               case (req_data.kind)
                  KIND_PUSH: begin
                     if (cnt_ff >= STACK_MAX) begin
                        status_in = STATUS_STACK_FULL;
                     end else if (in_txn && log_full) begin
                        status_in = STATUS_LOG_FULL;
                     end else begin
                        stk_wr_en = 1'b1;
                        cnt_in    = cnt_ff + CNT_ONE;
                        top_in    = req_data.value;
                        if (in_txn) begin
                           log_wr_en  = 1'b1;
                           log_cnt_in = log_cnt_ff + LOG_ONE;
                        end
                     end
                  end
                  KIND_POP: begin
                     if (cnt_ff != '0) begin
                        if (in_txn && log_full) begin
                           status_in = STATUS_LOG_FULL;
                        end else begin
                           cnt_in = cnt_dec;
                           if (in_txn) begin
                              log_wr_en   = 1'b1;
                              log_wr_data = {1'b0, top_ff};
                              log_cnt_in  = log_cnt_ff + LOG_ONE;
                           end
                           if (cnt_ff > CNT_ONE) begin
                              stk_rd_en   = 1'b1;
                              stk_rd_addr = cnt_dec2[SA_W-1:0];
                              state_in    = ST_FETCH;
                           end
                        end
                     end
                  end
                  KIND_BEGIN: begin
                     if (nest_ff >= NEST_MAX) begin
                        status_in = STATUS_NEST_FULL;
                     end else begin
                        mark_wr_en = 1'b1;
                        nest_in    = nest_ff + NEST_ONE;
                     end
                  end
                  KIND_COMMIT: begin
                     if (!in_txn) begin
                        status_in = STATUS_NO_TXN;
                     end else begin
                        nest_in = nest_dec;
                        if (nest_dec == '0) begin
                           log_cnt_in = '0;
                        end
                     end
                  end
                  KIND_ROLLBACK: begin
                     if (!in_txn) begin
                        status_in = STATUS_NO_TXN;
                     end else begin
                        nest_in    = nest_dec;
                        mark_rd_en = 1'b1;
                        state_in   = ST_UNDO_ADDR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_UNDO_ADDR: begin
            if (log_cnt_ff > mark_rd_data) begin
               log_rd_en  = 1'b1;
               log_cnt_in = log_cnt_dec;
               state_in   = ST_UNDO_DATA;
            end else if (cnt_ff != '0) begin
               stk_rd_en = 1'b1;
               state_in  = ST_FETCH;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_UNDO_DATA: begin
            // Undo a push by dropping the top, undo a pop by restoring its value.
            if (log_rd_data[VALUE_W]) begin
               if (cnt_ff != '0) begin
                  cnt_in = cnt_dec;
               end
            end else if (cnt_ff < STACK_MAX) begin
               stk_wr_en   = 1'b1;
               stk_wr_data = log_rd_data[VALUE_W-1:0];
               cnt_in      = cnt_ff + CNT_ONE;
            end
            state_in = ST_UNDO_ADDR;
         end
         ST_FETCH: begin
            top_in   = stk_rd_data;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.top_value = (cnt_ff != '0) ? top_ff : '0;
               rsp_data_in.depth     = DEPTH_OUT_W'(cnt_ff);
               rsp_data_in.status    = status_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   tstk_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   tstk_ram #(
      .WIDTH (LOG_ENTRY_W),
      .DEPTH (LOG_DEPTH)
   ) u_log_mem (
      .clock   (clock),
      .wr_en   (log_wr_en),
      .wr_addr (log_wr_addr),
      .wr_data (log_wr_data),
      .rd_en   (log_rd_en),
      .rd_addr (log_rd_addr),
      .rd_data (log_rd_data)
   );

   tstk_ram #(
      .WIDTH (LC_W),
      .DEPTH (NEST_DEPTH)
   ) u_mark_mem (
      .clock   (clock),
      .wr_en   (mark_wr_en),
      .wr_addr (mark_wr_addr),
      .wr_data (mark_wr_data),
      .rd_en   (mark_rd_en),
      .rd_addr (mark_rd_addr),
      .rd_data (mark_rd_data)
   );

`ifndef SYNTHESIS
   // The stack count never passes the stack size.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= STACK_MAX)
      else $error("stack count exceeds stack size");

   // Between operations, an empty transaction nest means an empty undo log.
   a_log_empty_outside_txn: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && nest_ff == '0) |-> (log_cnt_ff == '0))
      else $error("undo log not empty with no open transaction");

   // A rollback log read always addresses an entry below the log count.
   a_undo_read_valid: assert property (@(posedge clock) disable iff (reset)
      log_rd_en |-> (log_cnt_ff != '0 && state_ff == ST_UNDO_ADDR))
      else $error("undo log read with empty log");

   // A new result is loaded only into a free or draining output register.
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE))
      else $error("result left done state while output held");
`endif

endmodule

// ----- hw/rtl/tstk_ram.sv -----
// Single-port-write, single-port-read synchronous memory with registered read data.
module tstk_ram
   import tstk_pkg::*;
#(
   parameter int WIDTH = VALUE_W,
   parameter int DEPTH = STACK_DEPTH_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
